### src/gbfs_pkg.sv
// Shared constants, types and control bundle for the grid search block.
package gbfs_pkg;

  localparam int unsigned MaxRows = 64;
  localparam int unsigned MaxCols = 64;
  localparam int unsigned RowW    = $clog2(MaxRows);
  localparam int unsigned ColW    = $clog2(MaxCols);
  localparam int unsigned DimW    = 7;
  localparam int unsigned DistW   = 12;
  localparam logic [DistW-1:0] DistMax = '1;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    logic               wr_en;
    logic [RowW-1:0]    wr_row;
    logic [ColW-1:0]    wr_col;
    logic               wr_open;
    logic               seed;
    logic [RowW-1:0]    src_row;
    logic [ColW-1:0]    src_col;
    logic               step;
    logic [RowW-1:0]    dst_row;
    logic [ColW-1:0]    dst_col;
    logic [MaxCols-1:0] col_mask;
    logic [DimW-1:0]    row_lim;
  } cell_ctrl_t;

endpackage

### src/gbfs_row_cell.sv
// One grid row: open map, visited mask and one wavefront step per cycle while step is set.
module gbfs_row_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [gbfs_pkg::RowW-1:0]     row_idx_i,
  input  gbfs_pkg::cell_ctrl_t          ctrl_i,
  input  logic [gbfs_pkg::MaxCols-1:0]  up_vis_i,
  input  logic [gbfs_pkg::MaxCols-1:0]  dn_vis_i,
  output logic [gbfs_pkg::MaxCols-1:0]  vis_o,
  output logic                          hit_o,
  output logic                          grow_o
);

  logic [gbfs_pkg::MaxCols-1:0] open_q;
  logic [gbfs_pkg::MaxCols-1:0] vis_q, vis_d;
  logic [gbfs_pkg::MaxCols-1:0] fresh;
  logic                         row_en;

  assign row_en = ({1'b0, row_idx_i} < ctrl_i.row_lim);
  assign fresh  = (vis_q | (vis_q << 1) | (vis_q >> 1) | up_vis_i | dn_vis_i)
                  & open_q & ctrl_i.col_mask & ~vis_q & {gbfs_pkg::MaxCols{row_en}};
  assign grow_o = |fresh;
  assign hit_o  = (row_idx_i == ctrl_i.dst_row) && vis_q[ctrl_i.dst_col];
  assign vis_o  = vis_q;

  always_comb begin
    vis_d = vis_q;
    if (ctrl_i.seed) begin
      vis_d = '0;
      if (row_idx_i == ctrl_i.src_row) begin
        vis_d[ctrl_i.src_col] = 1'b1;
      end
    end else if (ctrl_i.step) begin
      vis_d = vis_q | fresh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0;
    end else begin
      vis_q <= vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en && row_idx_i == ctrl_i.wr_row) begin
      open_q[ctrl_i.wr_col] <= ctrl_i.wr_open;
    end
  end

endmodule

### src/grid_bfs_shortest_path.sv
// Grid shortest-path search: a chain of row cells expanding a wavefront.
// A write request (action 0) gives no result. A query request (action 1)
// holds busy while the wavefront grows one step per cycle across all row
// cells at once; the result strobe done_o comes once the target is reached or
// the wavefront stops growing, and in the cycle after acceptance when source
// or target lies outside the rows and columns in use. Results last exactly
// one cycle.
module grid_bfs_shortest_path (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [gbfs_pkg::DimW-1:0]      cfg_data_i,
  input  logic                           action_i,
  input  logic [gbfs_pkg::RowW-1:0]      cell_row_i,
  input  logic [gbfs_pkg::ColW-1:0]      cell_col_i,
  input  logic                           cell_open_i,
  input  logic [gbfs_pkg::RowW-1:0]      src_row_i,
  input  logic [gbfs_pkg::ColW-1:0]      src_col_i,
  input  logic [gbfs_pkg::RowW-1:0]      dst_row_i,
  input  logic [gbfs_pkg::ColW-1:0]      dst_col_i,
  output logic                           done_o,
  output logic                           reachable_o,
  output logic [gbfs_pkg::DistW-1:0]     distance_o
);

  gbfs_pkg::state_e            state_q, state_d;
  gbfs_pkg::cell_ctrl_t        ctrl;
  logic [gbfs_pkg::DimW-1:0]   rows_q, cols_q, nr, nc;
  logic [gbfs_pkg::RowW-1:0]   dst_row_q, dst_row_d;
  logic [gbfs_pkg::ColW-1:0]   dst_col_q, dst_col_d;
  logic [gbfs_pkg::DistW-1:0]  dist_q, dist_d;
  logic                        done_q, done_d, reach_q, reach_d;
  logic [gbfs_pkg::DistW-1:0]  res_q, res_d;
  logic                        accept, in_range;
  logic [gbfs_pkg::MaxCols-1:0] vis [gbfs_pkg::MaxRows];
  logic [gbfs_pkg::MaxRows-1:0] hit, grow;
  logic                        any_hit, any_grow;

  always_comb begin
    nr = rows_q;
    if (rows_q == '0) nr = gbfs_pkg::DimW'(1);
    else if (rows_q > gbfs_pkg::DimW'(gbfs_pkg::MaxRows)) nr = gbfs_pkg::DimW'(gbfs_pkg::MaxRows);
    nc = cols_q;
    if (cols_q == '0) nc = gbfs_pkg::DimW'(1);
    else if (cols_q > gbfs_pkg::DimW'(gbfs_pkg::MaxCols)) nc = gbfs_pkg::DimW'(gbfs_pkg::MaxCols);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gbfs_pkg::DimW'(gbfs_pkg::MaxRows);
      cols_q <= gbfs_pkg::DimW'(gbfs_pkg::MaxCols);
    end else if (cfg_we_i) begin
      unique case (gbfs_pkg::cfg_idx_e'(cfg_idx_i))
        gbfs_pkg::CFG_ROWS: rows_q <= cfg_data_i;
        gbfs_pkg::CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy     = (state_q != gbfs_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, src_row_i} < nr) && ({1'b0, src_col_i} < nc) &&
                    ({1'b0, dst_row_i} < nr) && ({1'b0, dst_col_i} < nc);
  assign any_hit  = |hit;
  assign any_grow = |grow;

  always_comb begin
    state_d   = state_q;
    dst_row_d = dst_row_q;
    dst_col_d = dst_col_q;
    dist_d    = dist_q;
    done_d    = 1'b0;
    reach_d   = 1'b0;
    res_d     = '0;
    ctrl          = '0;
    ctrl.wr_row   = cell_row_i;
    ctrl.wr_col   = cell_col_i;
    ctrl.wr_open  = cell_open_i;
    ctrl.src_row  = src_row_i;
    ctrl.src_col  = src_col_i;
    ctrl.dst_row  = dst_row_q;
    ctrl.dst_col  = dst_col_q;
    ctrl.row_lim  = nr;
    for (int c = 0; c < gbfs_pkg::MaxCols; c++) begin
      ctrl.col_mask[c] = (gbfs_pkg::DimW'(c) < nc);
    end
    unique case (state_q)
      gbfs_pkg::ST_IDLE: begin
        if (accept) begin
          if (gbfs_pkg::action_e'(action_i) == gbfs_pkg::ACT_WRITE) begin
            ctrl.wr_en = 1'b1;
          end else if (in_range) begin
            ctrl.seed = 1'b1;
            dst_row_d = dst_row_i;
            dst_col_d = dst_col_i;
            dist_d    = '0;
            state_d   = gbfs_pkg::ST_SEARCH;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      gbfs_pkg::ST_SEARCH: begin
        if (any_hit) begin
          done_d  = 1'b1;
          reach_d = 1'b1;
          res_d   = dist_q;
          state_d = gbfs_pkg::ST_IDLE;
        end else if (!any_grow) begin
          done_d  = 1'b1;
          state_d = gbfs_pkg::ST_IDLE;
        end else begin
          ctrl.step = 1'b1;
          if (dist_q != gbfs_pkg::DistMax) dist_d = dist_q + 1'b1;
        end
      end
      default: state_d = gbfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbfs_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dst_row_q <= dst_row_d;
    dst_col_q <= dst_col_d;
    dist_q    <= dist_d;
    reach_q   <= reach_d;
    res_q     <= res_d;
  end

  for (genvar r = 0; r < gbfs_pkg::MaxRows; r++) begin : g_row
    logic [gbfs_pkg::MaxCols-1:0] up_vis, dn_vis;
    if (r == 0) begin : g_top
      assign up_vis = '0;
    end else begin : g_mid
      assign up_vis = vis[r-1];
    end
    if (r == gbfs_pkg::MaxRows - 1) begin : g_bot
      assign dn_vis = '0;
    end else begin : g_low
      assign dn_vis = vis[r+1];
    end
    gbfs_row_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .row_idx_i (gbfs_pkg::RowW'(r)),
      .ctrl_i    (ctrl),
      .up_vis_i  (up_vis),
      .dn_vis_i  (dn_vis),
      .vis_o     (vis[r]),
      .hit_o     (hit[r]),
      .grow_o    (grow[r])
    );
  end

  assign done_o      = done_q;
  assign reachable_o = done_q && reach_q;
  assign distance_o  = done_q ? res_q : '0;

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbfs_pkg::ST_SEARCH && any_hit) |=> (done_o && reachable_o))
    else $error("hit not reported");
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !reachable_o) |-> (distance_o == '0))
    else $error("unreachable result with distance");
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == gbfs_pkg::ST_SEARCH || $past(accept)))
    else $error("result without request");
  a_search_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbfs_pkg::ST_SEARCH && !any_hit && !any_grow) |=> !busy)
    else $error("search did not end");

endmodule

### dv/grid_bfs_shortest_path_test.sv
// Testbench for the grid search block: random grids and queries checked against a search model.
module grid_bfs_shortest_path_test;

  typedef struct {
    gbfs_pkg::action_e               act;
    logic [gbfs_pkg::RowW-1:0]       cell_row;
    logic [gbfs_pkg::ColW-1:0]       cell_col;
    logic                            cell_open;
    logic [gbfs_pkg::RowW-1:0]       src_row;
    logic [gbfs_pkg::ColW-1:0]       src_col;
    logic [gbfs_pkg::RowW-1:0]       dst_row;
    logic [gbfs_pkg::ColW-1:0]       dst_col;
  } request_t;

  typedef struct {
    logic                       reachable;
    logic [gbfs_pkg::DistW-1:0] distance;
  } answer_t;

  localparam int Cells = int'(gbfs_pkg::MaxRows * gbfs_pkg::MaxCols);
  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [gbfs_pkg::DimW-1:0] cfg_data_i = '0;
  logic action_i = 1'b0;
  logic [gbfs_pkg::RowW-1:0] cell_row_i = '0;
  logic [gbfs_pkg::ColW-1:0] cell_col_i = '0;
  logic cell_open_i = 1'b0;
  logic [gbfs_pkg::RowW-1:0] src_row_i = '0;
  logic [gbfs_pkg::ColW-1:0] src_col_i = '0;
  logic [gbfs_pkg::RowW-1:0] dst_row_i = '0;
  logic [gbfs_pkg::ColW-1:0] dst_col_i = '0;
  logic done_o;
  logic reachable_o;
  logic [gbfs_pkg::DistW-1:0] distance_o;

  grid_bfs_shortest_path u_dut (.*);

  always #4 clk_i = ~clk_i;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  bit       grid_open[Cells];
  bit       seen[Cells];
  int       frontier_cell[Cells];
  int       frontier_dist[Cells];
  logic [gbfs_pkg::DimW-1:0] rows_reg = 7'd64;
  logic [gbfs_pkg::DimW-1:0] cols_reg = 7'd64;
  int  errors = 0;
  int  idle_cycles = 0;
  int  gap = 0;
  bit  burst = 1'b0;
  bit  accepted = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int clamp_dim(input logic [gbfs_pkg::DimW-1:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic answer_t search_grid(input int sr, input int sc, input int dr, input int dc);
    int nr, nc, head, tail, r, c, vr, vc, vi, d;
    int step_r[4];
    int step_c[4];
    answer_t ans;
    step_r = '{-1, 0, 1, 0};
    step_c = '{0, 1, 0, -1};
    nr = clamp_dim(rows_reg, gbfs_pkg::MaxRows);
    nc = clamp_dim(cols_reg, gbfs_pkg::MaxCols);
    ans.reachable = 1'b0;
    ans.distance = '0;
    if (sr >= nr || sc >= nc || dr >= nr || dc >= nc) return ans;
    foreach (seen[i]) seen[i] = 1'b0;
    head = 0;
    tail = 1;
    frontier_cell[0] = sr * gbfs_pkg::MaxCols + sc;
    frontier_dist[0] = 0;
    seen[sr * gbfs_pkg::MaxCols + sc] = 1'b1;
    while (head < tail) begin
      r = frontier_cell[head] / gbfs_pkg::MaxCols;
      c = frontier_cell[head] % gbfs_pkg::MaxCols;
      d = frontier_dist[head];
      head++;
      if (r == dr && c == dc) begin
        ans.reachable = 1'b1;
        ans.distance = (d > int'(gbfs_pkg::DistMax)) ? gbfs_pkg::DistMax :
                                                       d[gbfs_pkg::DistW-1:0];
        return ans;
      end
      for (int k = 0; k < 4; k++) begin
        vr = r + step_r[k];
        vc = c + step_c[k];
        if (vr < 0 || vr >= nr || vc < 0 || vc >= nc) continue;
        vi = vr * gbfs_pkg::MaxCols + vc;
        if (grid_open[vi] && !seen[vi]) begin
          seen[vi] = 1'b1;
          frontier_cell[tail] = vi;
          frontier_dist[tail] = d + 1;
          tail++;
        end
      end
    end
    return ans;
  endfunction

  // accept requests, predict answers, check results
  always @(posedge clk_i) begin
    accepted = start && !busy;
    if (accepted) begin
      if (gbfs_pkg::action_e'(action_i) == gbfs_pkg::ACT_WRITE) begin
        grid_open[int'(cell_row_i) * gbfs_pkg::MaxCols + int'(cell_col_i)] = cell_open_i;
      end else begin
        expected_answers.insert(expected_answers.size(),
                                search_grid(int'(src_row_i), int'(src_col_i),
                                            int'(dst_row_i), int'(dst_col_i)));
      end
    end
    if (done_o) begin
      if (expected_answers.size() == 0) begin
        report("unexpected result", int'(reachable_o), 0);
      end else begin
        answer_t a;
        a = expected_answers.pop_front();
        if (reachable_o !== a.reachable)
          report("reachable", int'(reachable_o), int'(a.reachable));
        if (distance_o !== a.distance)
          report("distance", int'(distance_o), int'(a.distance));
      end
    end
    if (accepted || done_o || (pending_reqs.size() == 0 && expected_answers.size() == 0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // drive requests at the falling edge
  always @(negedge clk_i) begin
    logic start_n;
    request_t req;
    start_n = start && !accepted;
    if (rst_ni && !start_n) begin
      if (gap > 0) begin
        gap--;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        action_i <= req.act;
        cell_row_i <= req.cell_row;
        cell_col_i <= req.cell_col;
        cell_open_i <= req.cell_open;
        src_row_i <= req.src_row;
        src_col_i <= req.src_col;
        dst_row_i <= req.dst_row;
        dst_col_i <= req.dst_col;
        start_n = 1'b1;
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : int'($urandom_range(0, 12));
      end
    end
    start <= start_n;
  end

  task automatic add_write(input int r, input int c, input bit is_open);
    request_t q;
    q.act       = gbfs_pkg::ACT_WRITE;
    q.cell_row  = gbfs_pkg::RowW'(r);
    q.cell_col  = gbfs_pkg::ColW'(c);
    q.cell_open = is_open;
    q.src_row   = gbfs_pkg::RowW'($urandom);
    q.src_col   = gbfs_pkg::ColW'($urandom);
    q.dst_row   = gbfs_pkg::RowW'($urandom);
    q.dst_col   = gbfs_pkg::ColW'($urandom);
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic add_query(input int sr, input int sc, input int dr, input int dc);
    request_t q;
    q.act       = gbfs_pkg::ACT_QUERY;
    q.cell_row  = gbfs_pkg::RowW'($urandom);
    q.cell_col  = gbfs_pkg::ColW'($urandom);
    q.cell_open = 1'($urandom);
    q.src_row   = gbfs_pkg::RowW'(sr);
    q.src_col   = gbfs_pkg::ColW'(sc);
    q.dst_row   = gbfs_pkg::RowW'(dr);
    q.dst_col   = gbfs_pkg::ColW'(dc);
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  task automatic settle();
    wait (pending_reqs.size() == 0 && !start && expected_answers.size() == 0 && !busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input gbfs_pkg::cfg_idx_e idx,
                           input logic [gbfs_pkg::DimW-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gbfs_pkg::CFG_ROWS) rows_reg = value;
    else cols_reg = value;
  endtask

  // every cell of the nr x nc region must already be written
  task automatic random_phase(input int n, input int nr, input int nc);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        add_write($urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                  $urandom_range(0, 3) != 0);
      else if ($urandom_range(0, 7) == 0)
        add_query($urandom_range(0, 63), $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 63));
      else
        add_query($urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                  $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
    end
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // full grid: only cells around (40, 40) are written
    add_write(40, 41, 1'b1);
    add_write(39, 40, 1'b0);
    add_write(41, 40, 1'b0);
    add_write(40, 39, 1'b0);
    add_query(17, 42, 17, 42);
    add_query(40, 40, 40, 41);
    settle();
    write_reg(gbfs_pkg::CFG_ROWS, 7'd6);
    write_reg(gbfs_pkg::CFG_COLS, 7'd7);
    for (int r = 0; r < 6; r++)
      for (int c = 0; c < 7; c++)
        add_write(r, c, $urandom_range(0, 3) != 0);
    add_query(6, 0, 0, 0);
    add_query(0, 0, 0, 7);
    add_query(0, 0, 5, 6);
    random_phase(9, 6, 7);
    write_reg(gbfs_pkg::CFG_ROWS, 7'd0);
    write_reg(gbfs_pkg::CFG_COLS, 7'd127);
    add_write(0, 7, 1'b0);
    add_query(0, 0, 0, 0);
    add_query(1, 0, 0, 0);
    add_query(0, 63, 0, 63);
    add_query(0, 0, 0, 6);
    add_query(0, 6, 0, 63);
    settle();
    write_reg(gbfs_pkg::CFG_ROWS, 7'd100);
    write_reg(gbfs_pkg::CFG_COLS, 7'd0);
    add_write(6, 0, 1'b0);
    add_query(63, 0, 63, 0);
    add_query(10, 0, 10, 1);
    add_query(0, 0, 5, 0);
    add_query(5, 0, 40, 0);
    settle();
    write_reg(gbfs_pkg::CFG_ROWS, 7'd8);
    write_reg(gbfs_pkg::CFG_COLS, 7'd8);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        if (r >= 6 || c >= 7) add_write(r, c, $urandom_range(0, 3) != 0);
    random_phase(20, 8, 8);
    write_reg(gbfs_pkg::CFG_ROWS, 7'd64);
    write_reg(gbfs_pkg::CFG_COLS, 7'd64);
    add_query(63, 63, 63, 63);
    add_query(40, 40, 40, 41);
    settle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
